[rtl/mhpq_pkg.sv]
// shared types and constants for the max-heap priority queue
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

  localparam int KEY_W       = 32;
  localparam int ENTRIES_W   = 7;
  localparam int CAPACITY_DF = 64;

  // request kinds (kind three decodes as a peek)
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_PEEK   = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/mhpq_cell.sv]
// one slot of the sorted chain: holds a key and shifts right on insert, left on remove
`timescale 1ns / 1ps
`default_nettype none

module mhpq_cell (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire mhpq_pkg::cell_ctl_t              ctl,
  input  wire logic signed [mhpq_pkg::KEY_W-1:0] ins_key,
  input  wire logic signed [mhpq_pkg::KEY_W-1:0] prev_key,
  input  wire logic                             prev_vld,
  input  wire logic                             prev_take,
  input  wire logic signed [mhpq_pkg::KEY_W-1:0] next_key,
  input  wire logic                             next_vld,
  output logic signed [mhpq_pkg::KEY_W-1:0]      key,
  output logic                                  vld,
  output logic                                  take
);

  logic signed [mhpq_pkg::KEY_W-1:0] key_r, key_nxt;
  logic                              vld_r, vld_nxt;

  // slot gets displaced when empty or when the new key beats it
  assign take = !vld_r || (ins_key > key_r);

  always_comb begin
    key_nxt = key_r;
    vld_nxt = vld_r;
    if (ctl.ins && take) begin
      if (prev_take) begin
        key_nxt = prev_key;
        vld_nxt = prev_vld;
      end else begin
        key_nxt = ins_key;
        vld_nxt = 1'b1;
      end
    end else if (ctl.rem) begin
      key_nxt = next_key;
      vld_nxt = next_vld;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign key = key_r;
  assign vld = vld_r;

endmodule

`default_nettype wire

[rtl/max_heap_priority_queue.sv]
// top level of the max priority queue built as a sorted chain of key cells
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  ports                        words carry
// -------  ---------  ---------------------------  ----------------------------------
// in       slave      in_tvalid/tready/tdata/tuser  kind in tuser, key_in in tdata
// out      master     out_tvalid/tready/tdata/tuser status in tuser, key_out+entries in tdata
//
// one word a cycle: a request is handled in the cycle it is accepted, set by
// the single broadcast compare of the incoming key against every cell of the chain
// reset empties the chain at once (per-cell valid bits), no clearing pass
// the result sits in an output register; a new word is taken whenever that
// register is empty or being drained, so a stalled output holds the input back

module max_heap_priority_queue #(
  parameter int CAPACITY = mhpq_pkg::CAPACITY_DF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] key_in
  input  wire logic [1:0]  in_tuser,   // [1:0] kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [31:0] key_out, [38:32] entries, [39] zero
  output logic [1:0]       out_tuser   // [1:0] status
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int KW    = mhpq_pkg::KEY_W;

  // cell chain wiring, index 0 holds the maximum
  logic signed [KW-1:0] cell_key  [CAPACITY];
  logic                 cell_vld  [CAPACITY];
  logic                 cell_take [CAPACITY];

  mhpq_pkg::cell_ctl_t ctl;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_vld_r;
  logic [1:0]       status_r, status_nxt;
  logic [KW-1:0]    key_out_r, key_out_nxt;
  logic [mhpq_pkg::ENTRIES_W-1:0] entries_r;

  logic acc, is_ins, is_rem, full, empty;
  logic signed [KW-1:0] key_in;

  assign key_in    = in_tdata[KW-1:0];
  assign in_tready = !out_vld_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign full      = (cnt_r == CNT_W'(CAPACITY));
  assign empty     = (cnt_r == '0);

  // decode kind, anything not insert or remove is a peek
  always_comb begin
    is_ins = 1'b0;
    is_rem = 1'b0;
    case (in_tuser)
      mhpq_pkg::KIND_INSERT: is_ins = 1'b1;
      mhpq_pkg::KIND_REMOVE: is_rem = 1'b1;
      default: begin
        is_ins = 1'b0;
        is_rem = 1'b0;
      end
    endcase
  end

  assign ctl.ins = acc && is_ins && !full;
  assign ctl.rem = acc && is_rem && !empty;

  // result and new count
  always_comb begin
    cnt_nxt     = cnt_r;
    status_nxt  = mhpq_pkg::STAT_DONE;
    key_out_nxt = '0;
    if (is_ins) begin
      if (full) begin
        status_nxt = mhpq_pkg::STAT_FULL;
      end else begin
        cnt_nxt     = cnt_r + CNT_W'(1);
        key_out_nxt = key_in;
      end
    end else if (empty) begin
      status_nxt = mhpq_pkg::STAT_EMPTY;
    end else begin
      key_out_nxt = cell_key[0];
      if (is_rem) begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  // the chain: each cell sees its neighbors' keys and take flags
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [KW-1:0] pk, nk;
    logic                 pv, pt, nv;
    if (i == 0) begin : g_head
      assign pk = '0;
      assign pv = 1'b0;
      assign pt = 1'b0;
    end else begin : g_mid
      assign pk = cell_key[i-1];
      assign pv = cell_vld[i-1];
      assign pt = cell_take[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign nk = '0;
      assign nv = 1'b0;
    end else begin : g_body
      assign nk = cell_key[i+1];
      assign nv = cell_vld[i+1];
    end
    mhpq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .ins_key   (key_in),
      .prev_key  (pk),
      .prev_vld  (pv),
      .prev_take (pt),
      .next_key  (nk),
      .next_vld  (nv),
      .key       (cell_key[i]),
      .vld       (cell_vld[i]),
      .take      (cell_take[i])
    );
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      status_r  <= status_nxt;
      key_out_r <= key_out_nxt;
      entries_r <= mhpq_pkg::ENTRIES_W'(cnt_nxt);
    end
    if (!rst_n) begin
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (acc) begin
        cnt_r <= cnt_nxt;
      end
      if (acc) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {1'b0, entries_r, key_out_r};

endmodule

`default_nettype wire

[bench/heap_queue_checker.sv]
// checker for the max-heap priority queue: predicts each result word and compares it
`timescale 1ns / 1ps

module heap_queue_checker #(
  parameter int CAPACITY = mhpq_pkg::CAPACITY_DF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] key;
    logic [6:0]         entries;
  } heap_result_t;

  logic signed [31:0] heap_keys [CAPACITY];
  int                 heap_fill = 0;
  heap_result_t       expected_results [$];
  int                 fail_total = 0;

  assign mismatches = fail_total;

  function automatic void swap_keys(input int a, input int b);
    logic signed [31:0] t;
    t            = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endfunction

  // applies one request to the shadow heap and returns the word it should produce
  function automatic heap_result_t apply_request(input logic [1:0] kind,
                                                 input logic signed [31:0] key);
    heap_result_t r;
    int           pos;
    int           parent;
    int           best;
    int           lchild;
    int           rchild;
    bit           moving;
    r.status = mhpq_pkg::STAT_DONE;
    r.key    = '0;
    if (kind == mhpq_pkg::KIND_INSERT) begin
      if (heap_fill >= CAPACITY) begin
        r.status = mhpq_pkg::STAT_FULL;
      end else begin
        heap_keys[heap_fill] = key;
        pos                  = heap_fill;
        heap_fill++;
        moving = 1'b1;
        while (moving && pos > 0) begin
          parent = (pos - 1) / 2;
          if (heap_keys[pos] > heap_keys[parent]) begin
            swap_keys(pos, parent);
            pos = parent;
          end else begin
            moving = 1'b0;
          end
        end
        r.key = key;
      end
    end else if (kind == mhpq_pkg::KIND_REMOVE) begin
      if (heap_fill == 0) begin
        r.status = mhpq_pkg::STAT_EMPTY;
      end else begin
        r.key        = heap_keys[0];
        heap_keys[0] = heap_keys[heap_fill - 1];
        heap_fill--;
        pos    = 0;
        moving = 1'b1;
        // larger child wins, left on a tie, only when strictly greater
        while (moving && pos < heap_fill) begin
          best   = pos;
          lchild = 2 * pos + 1;
          rchild = 2 * pos + 2;
          if (lchild < heap_fill && heap_keys[lchild] > heap_keys[best]) best = lchild;
          if (rchild < heap_fill && heap_keys[rchild] > heap_keys[best]) best = rchild;
          if (best == pos) begin
            moving = 1'b0;
          end else begin
            swap_keys(pos, best);
            pos = best;
          end
        end
      end
    end else if (heap_fill == 0) begin
      // peek, selector three included
      r.status = mhpq_pkg::STAT_EMPTY;
    end else begin
      r.key = heap_keys[0];
    end
    r.entries = 7'(heap_fill);
    return r;
  endfunction

  always @(posedge clk) begin
    heap_result_t got;
    heap_result_t want;
    if (!rst_n) begin
      heap_fill = 0;
      expected_results.delete();
    end else begin
      // result side first: the output register always holds an older request
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata[31:0], out_tdata[38:32]};
        if (expected_results.size() == 0) begin
          $error("result word with no request outstanding");
          fail_total++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
            fail_total++;
          end
          if (got.key !== want.key) begin
            $error("key_out mismatch: expected %0d, actual %0d",
                   $signed(want.key), $signed(got.key));
            fail_total++;
          end
          if (got.entries !== want.entries) begin
            $error("entries mismatch: expected %0d, actual %0d", want.entries, got.entries);
            fail_total++;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_request(in_tuser, in_tdata));
    end
    outstanding = expected_results.size();
  end

endmodule

[bench/max_heap_priority_queue_tb.sv]
// testbench top for the max-heap priority queue: stimulus, flow control and verdict
`timescale 1ns / 1ps

module max_heap_priority_queue_tb;

  localparam int HEAP_DEPTH     = mhpq_pkg::CAPACITY_DF;
  localparam int PHASES         = 8;
  localparam int PHASE_WORDS    = 100;
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake at all
  localparam int DRAIN_CYCLES   = 20;
  localparam int IDLE_PCT       = 83;
  localparam int LIGHT_IDLE_PCT = 6;

  // the selector value three also decodes as a peek
  localparam logic [1:0] KIND_PEEK_ALT = 2'd3;

  // request mix of a random phase
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} req_mix_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] key_in
  logic [1:0]  in_tuser;   // [1:0] kind
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [31:0] key_out, [38:32] entries, [39] zero
  logic [1:0]  out_tuser;  // [1:0] status

  int mismatches;
  int outstanding;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_requests = 0;   // bumped by stimulus, served by the receiver
  int holds_served  = 0;
  int quiet_cycles  = 0;

  // fill phases reach full, drain phases reach empty, idling modes rotate
  req_mix_t phase_mix [PHASES] = '{MIX_FILL, MIX_FILL, MIX_DRAIN, MIX_EVEN,
                                   MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_DRAIN};

  max_heap_priority_queue #(.CAPACITY(HEAP_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  heap_queue_checker #(.CAPACITY(HEAP_DEPTH)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offers one request word, with random idle cycles ahead of it,
  // and returns right after the edge that accepted it
  task automatic send_word(input logic [1:0] kind, input logic [31:0] key);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= key;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [1:0] pick_kind(input req_mix_t mix);
    int roll;
    int ins_pct;
    int rem_pct;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        ins_pct = 88;
        rem_pct = 6;
      end
      MIX_DRAIN: begin
        ins_pct = 6;
        rem_pct = 88;
      end
      default: begin
        ins_pct = 45;
        rem_pct = 35;
      end
    endcase
    if (roll < ins_pct) return mhpq_pkg::KIND_INSERT;
    if (roll < ins_pct + rem_pct) return mhpq_pkg::KIND_REMOVE;
    return $urandom_range(0, 1) ? KIND_PEEK_ALT : mhpq_pkg::KIND_PEEK;
  endfunction

  // extremes now and then, many near-equal keys for ties, the rest anywhere
  function automatic logic [31:0] pick_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      case ($urandom_range(0, 3))
        0:       return 32'h7fff_ffff;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    if (roll < 50) return 32'($signed($urandom_range(0, 16)) - 8);
    return $urandom;
  endfunction

  // receiver: random stalls, plus a long hold-off whenever stimulus asks for one
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // watchdog: any handshake restarts the count
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= mhpq_pkg::KIND_INSERT;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty heap errors, extreme keys, ties, selector three, drain past empty
    send_word(mhpq_pkg::KIND_PEEK,   32'h1234_5678);
    send_word(mhpq_pkg::KIND_REMOVE, 32'hdead_beef);
    send_word(KIND_PEEK_ALT,         32'h0000_0000);
    send_word(mhpq_pkg::KIND_INSERT, 32'h0000_0000);
    send_word(mhpq_pkg::KIND_INSERT, 32'h8000_0000);
    send_word(mhpq_pkg::KIND_PEEK,   32'h0000_0000);
    send_word(mhpq_pkg::KIND_INSERT, 32'h7fff_ffff);
    send_word(mhpq_pkg::KIND_INSERT, 32'hffff_ffff);
    send_word(mhpq_pkg::KIND_INSERT, 32'h0000_0005);
    send_word(mhpq_pkg::KIND_INSERT, 32'h0000_0005);
    send_word(KIND_PEEK_ALT,         32'hffff_ffff);
    send_word(mhpq_pkg::KIND_REMOVE, 32'h5555_5555);
    send_word(mhpq_pkg::KIND_PEEK,   32'haaaa_aaaa);
    send_word(mhpq_pkg::KIND_REMOVE, 32'h0000_0000);
    send_word(mhpq_pkg::KIND_REMOVE, 32'h0000_0000);
    send_word(mhpq_pkg::KIND_INSERT, 32'hffff_fffb);
    send_word(mhpq_pkg::KIND_REMOVE, 32'h0000_0000);
    send_word(mhpq_pkg::KIND_REMOVE, 32'h0000_0000);
    send_word(mhpq_pkg::KIND_REMOVE, 32'h0000_0000);
    send_word(mhpq_pkg::KIND_REMOVE, 32'h0000_0000);
    send_word(mhpq_pkg::KIND_REMOVE, 32'h0000_0000);
    send_word(KIND_PEEK_ALT,         32'h0000_0000);

    // random phases: idling rotates none, sender, receiver, both
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = IDLE_PCT;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = IDLE_PCT;
        end
        default: begin
          send_idle_pct = LIGHT_IDLE_PCT;
          stall_pct     = LIGHT_IDLE_PCT;
        end
      endcase
      // back-pressure: receiver holds off while the sender keeps offering words
      if (ph == 4) hold_requests++;
      repeat (PHASE_WORDS) send_word(pick_kind(phase_mix[ph]), pick_key());
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
